FILE: design/assert_macros.svh
// Assertion macros shared by the vertex cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rbvc_pkg.sv
// Types and constants of the reference-counted bucket vertex cache.
package rbvc_pkg;

	localparam int BUCKETS    = 4096;
	localparam int SLOTS      = 8;
	localparam int BUCKET_W   = 12;
	localparam int KEY_W      = 31;
	localparam int VTX_W      = 24;
	localparam int REFS_W     = 4;
	localparam int FILL_W     = 4;
	localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ENT_AW     = BKT_W + SLOT_W;
	localparam int ENT_DEPTH  = 1 << ENT_AW;
	localparam int FILL_DEPTH = 1 << BKT_W;

	localparam logic [REFS_W-1:0] RETIRE_RST = REFS_W'(4);
	localparam logic [REFS_W-1:0] REFS_NEW   = REFS_W'(1);

	typedef enum logic {
		MODE_LOOKUP = 1'b0,
		MODE_INSERT = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STS_HIT      = 2'd0,
		STS_MISS     = 2'd1,
		STS_INSERTED = 2'd2,
		STS_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		mode_t                 mode;
		logic [BUCKET_W-1:0]   bucket;
		logic [KEY_W-1:0]      key;
		logic [VTX_W-1:0]      vertex_in;
	} in_item_t;

	typedef struct packed {
		status_t               status;
		logic [VTX_W-1:0]      vertex_out;
		logic                  retired;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [VTX_W-1:0]      vertex;
		logic [REFS_W-1:0]     refs;
	} ent_t;

endpackage

FILE: design/rbvc_ram.sv
// Simple dual-port synchronous RAM with registered read.
module rbvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: design/refcounted_bucket_vertex_cache_core.sv
// Reference-counted bucket vertex cache. Each item is a lookup or an insert into the bucket
// it names (bucket index taken modulo BUCKETS). State lives in two synchronous RAMs: a fill
// count per bucket and an entry RAM of BUCKETS x SLOTS {key, vertex, refs}. One item is
// handled at a time. An insert reads the bucket fill count, writes the entry and the new
// count if a slot is free, and presents its result. A lookup reads the fill count and scans
// the slots until a hit or until all fill entries are scanned (miss), with a move step
// when a retired entry is replaced by the bucket's last entry. The scan length is set
// by the entry RAM's single read port, which yields one slot per cycle. After reset a
// clearing pass zeroes every bucket fill count, one bucket per cycle; no item is accepted
// during it, while retire threshold writes (cfg_we) are taken at any time. The result
// register lets the next item be accepted while a finished result waits on out_stall.
`include "assert_macros.svh"

module refcounted_bucket_vertex_cache_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rbvc_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output rbvc_pkg::out_item_t           out_item,
	input  logic                          cfg_we,
	input  logic [rbvc_pkg::REFS_W-1:0]   cfg_wdata
);

	import rbvc_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL,
		S_SCAN,
		S_MOVE,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [BKT_W-1:0]    clr_q;
	in_item_t            req_q;
	logic [BKT_W-1:0]    bkt_q;
	logic [REFS_W-1:0]   retire_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   idx_q;
	logic [VTX_W-1:0]    hit_vtx_q;
	out_item_t           res_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic                fill_we;
	logic [BKT_W-1:0]    fill_waddr;
	logic [FILL_W-1:0]   fill_wdata;
	logic [BKT_W-1:0]    fill_raddr;
	logic [FILL_W-1:0]   fill_rdata;
	logic                ent_we;
	logic [ENT_AW-1:0]   ent_waddr;
	ent_t                ent_wdata;
	logic [ENT_AW-1:0]   ent_raddr;
	ent_t                ent_rdata;

	logic [FILL_W-1:0]   fill_cur;
	logic [FILL_W-1:0]   fill_dec;
	logic [FILL_W-1:0]   idx_inc;
	logic                key_hit;
	logic [REFS_W-1:0]   refs_nx;
	logic                retire_hit;
	logic                is_last;
	logic                out_free;

	// State memories
	rbvc_ram #(.WIDTH(FILL_W), .DEPTH(FILL_DEPTH)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	rbvc_ram #(.WIDTH($bits(ent_t)), .DEPTH(ENT_DEPTH)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// Decode the read data of the current step
	assign fill_cur   = (fill_rdata > FILL_W'(SLOTS)) ? FILL_W'(SLOTS) : fill_rdata;
	assign fill_dec   = fill_q - FILL_W'(1);
	assign idx_inc    = idx_q + FILL_W'(1);
	assign key_hit    = (ent_rdata.key == req_q.key);
	assign refs_nx    = ent_rdata.refs + REFS_W'(1);
	assign retire_hit = (refs_nx == retire_q);
	assign is_last    = (idx_q == fill_dec);
	assign out_free   = !out_valid_q || !out_stall;

	// Drive memory ports for each step
	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = bkt_q;
		fill_wdata = '0;
		fill_raddr = BKT_W'(in_item.bucket % BUCKETS);
		ent_we     = 1'b0;
		ent_waddr  = {bkt_q, idx_q[SLOT_W-1:0]};
		ent_wdata  = ent_rdata;
		ent_raddr  = {bkt_q, SLOT_W'(0)};
		case (state_q)
			S_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
			end
			S_FILL: begin
				if (req_q.mode == MODE_INSERT && fill_cur < FILL_W'(SLOTS)) begin
					ent_we     = 1'b1;
					ent_waddr  = {bkt_q, fill_cur[SLOT_W-1:0]};
					ent_wdata  = '{key: req_q.key, vertex: req_q.vertex_in, refs: REFS_NEW};
					fill_we    = 1'b1;
					fill_wdata = fill_cur + FILL_W'(1);
				end
			end
			S_SCAN: begin
				if (key_hit && retire_hit) begin
					ent_raddr = {bkt_q, fill_dec[SLOT_W-1:0]};
					if (is_last) begin
						fill_we    = 1'b1;
						fill_wdata = fill_dec;
					end
				end else begin
					ent_raddr = {bkt_q, idx_inc[SLOT_W-1:0]};
					if (key_hit) begin
						ent_we         = 1'b1;
						ent_wdata.refs = refs_nx;
					end
				end
			end
			S_MOVE: begin
				// Move the last entry into the retired slot
				ent_we     = 1'b1;
				fill_we    = 1'b1;
				fill_wdata = fill_dec;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, request and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			req_q       <= '0;
			bkt_q       <= '0;
			retire_q    <= RETIRE_RST;
			fill_q      <= '0;
			idx_q       <= '0;
			hit_vtx_q   <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				retire_q <= cfg_wdata;
			end
			// Load a finished item into the output register, or drop a taken result
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_item;
						bkt_q   <= BKT_W'(in_item.bucket % BUCKETS);
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					fill_q <= fill_cur;
					idx_q  <= '0;
					if (req_q.mode == MODE_INSERT) begin
						res_q   <= '{status: (fill_cur < FILL_W'(SLOTS)) ? STS_INSERTED : STS_FULL,
							vertex_out: '0, retired: 1'b0};
						state_q <= S_DONE;
					end else begin
						res_q <= '{status: STS_MISS, vertex_out: '0, retired: 1'b0};
						if (fill_cur == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (key_hit) begin
						hit_vtx_q <= ent_rdata.vertex;
						res_q     <= '{status: STS_HIT, vertex_out: ent_rdata.vertex,
							retired: retire_hit};
						state_q   <= (retire_hit && !is_last) ? S_MOVE : S_DONE;
					end else if (idx_inc >= fill_q) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_MOVE: begin
					res_q   <= '{status: STS_HIT, vertex_out: hit_vtx_q, retired: 1'b1};
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hand the result to the output register once it is free
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`ASSERT_NEXT(a_accept_reads_fill, clk, arst_n, in_valid && !in_stall, state_q == S_FILL, "accepted item did not move to fill read")
	`ASSERT_IMPLIES(a_entry_write_bucket, clk, arst_n, ent_we, ent_waddr[ENT_AW-1 -: BKT_W] == bkt_q, "entry write outside current bucket")
	`ASSERT_IMPLIES(a_fill_bound, clk, arst_n, fill_we, fill_wdata <= FILL_W'(SLOTS), "bucket fill above slot capacity")
	`ASSERT_IMPLIES(a_retired_is_hit, clk, arst_n, out_valid && out_item.retired, out_item.status == STS_HIT, "retired flag on a non-hit result")

endmodule
